>>> sv/bfdh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-hashing bloom filter core.
// No dependencies.
package bfdh_pkg;

    localparam int PADDR_W   = 4;
    localparam int HASH_W    = 64;
    localparam int HCNT_W    = 6;
    localparam int BCNT_W    = 21;
    localparam int DIV_DIGIT = 4;

    localparam logic [1:0] REG_HASH_COUNT  = 2'd0;
    localparam logic [1:0] REG_BIT_COUNT   = 2'd1;
    localparam logic [1:0] REG_INDEX_ORDER = 2'd2;

    localparam logic [HCNT_W-1:0] HCNT_RESET = 6'd1;
    localparam logic [BCNT_W-1:0] BCNT_RESET = 21'd1048576;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
    } t_div_req;

endpackage

>>> sv/bfdh_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfdh_ram #(
    parameter int W = 64,
    parameter int D = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/bfdh_divider.sv
`timescale 1ns / 1ps
// Iterative remainder unit: 64-bit dividend mod an MW-bit divisor, 4 bits a cycle.
// Depends on bfdh_pkg.
module bfdh_divider
    import bfdh_pkg::*;
#(
    parameter int MW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_req      i_req,
    input  logic [MW-1:0] i_divisor,
    output logic          o_done,
    output logic [MW-1:0] o_rem
);
    localparam int STEPS = HASH_W / DIV_DIGIT;
    localparam int SCW   = $clog2(STEPS);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SCW-1:0]    r_cnt, n_cnt;
    logic [HASH_W-1:0] r_dvd, n_dvd;
    logic [MW-1:0]     r_rem, n_rem;

    always_comb begin
        logic [MW-1:0] t;
        logic [MW:0]   t2;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        t      = r_rem;
        for (int j = 0; j < DIV_DIGIT; j++) begin
            t2 = {t, r_dvd[HASH_W-1-j]};
            if (t2 >= {1'b0, i_divisor}) begin
                t2 = t2 - {1'b0, i_divisor};
            end
            t = t2[MW-1:0];
        end
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_req.dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = t;
            n_dvd = {r_dvd[HASH_W-DIV_DIGIT-1:0], {DIV_DIGIT{1'b0}}};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == SCW'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

>>> sv/bloom_filter_double_hash_core.sv
`timescale 1ns / 1ps
// Top level of the double-hashing bloom filter: config port, probe sequencer, bit store.
// Depends on bfdh_pkg, bfdh_ram, bfdh_divider.
//
// After reset the core clears its bit store, one 64-bit word a cycle, MAX_BITS/64
// words (16384 at the default), with busy high. A word is accepted when start is
// high and busy is low. Each probe runs the remainder unit (four dividend bits a
// cycle), then a store read, then sets or tests the bit. An add runs one probe per
// hash and a query stops at the first clear bit; with a zero hash count a word runs
// no probe. The result is shown on o_present for one cycle with o_valid high; it
// cannot be held off.
module bloom_filter_double_hash_core
    import bfdh_pkg::*;
#(
    parameter int MAX_BITS   = 1048576,
    parameter int MAX_HASHES = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_req_type,
    input  logic signed [HASH_W-1:0] i_hash_first,
    input  logic signed [HASH_W-1:0] i_hash_second,
    output logic                     o_valid,
    output logic                     o_present
);
    localparam int WORDS = MAX_BITS / 64;
    localparam int AW    = $clog2(WORDS);
    localparam int MW    = $clog2(MAX_BITS + 1);
    localparam int CW    = (MW > BCNT_W) ? MW : BCNT_W;
    localparam int KW    = $clog2(MAX_HASHES + 1);

    logic [HCNT_W-1:0] r_hash_count;
    logic [BCNT_W-1:0] r_bit_count;
    logic              r_index_order;

    t_state            r_state, n_state;
    logic [HASH_W-1:0] r_base, n_base;
    logic [HASH_W-1:0] r_step, n_step;
    logic              r_add, n_add;
    logic [KW-1:0]     r_cnt, n_cnt;
    logic [KW-1:0]     r_k, n_k;
    logic [MW-1:0]     r_m, n_m;
    logic [AW-1:0]     r_word, n_word;
    logic [5:0]        r_bit, n_bit;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_valid, n_valid;
    logic              r_present, n_present;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [63:0]       ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [63:0]       ram_rdata;
    t_div_req          div_req;
    logic              div_done;
    logic [MW-1:0]     div_rem;

    logic              cfg_we;
    logic [CW-1:0]     bc_ext;
    logic [CW-1:0]     m_eff;
    logic [KW-1:0]     k_eff;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count  <= HCNT_RESET;
            r_bit_count   <= BCNT_RESET;
            r_index_order <= 1'b0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_HASH_COUNT:  r_hash_count  <= pwdata[HCNT_W-1:0];
                REG_BIT_COUNT:   r_bit_count   <= pwdata[BCNT_W-1:0];
                REG_INDEX_ORDER: r_index_order <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HASH_COUNT:  prdata = {{(32-HCNT_W){1'b0}}, r_hash_count};
            REG_BIT_COUNT:   prdata = {{(32-BCNT_W){1'b0}}, r_bit_count};
            REG_INDEX_ORDER: prdata = {31'd0, r_index_order};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        bc_ext = CW'(r_bit_count);
        if (bc_ext < CW'(64)) begin
            m_eff = CW'(64);
        end else if (bc_ext > CW'(MAX_BITS)) begin
            m_eff = CW'(MAX_BITS);
        end else begin
            m_eff = bc_ext;
        end
        if ({1'b0, r_hash_count} > 7'(MAX_HASHES)) begin
            k_eff = KW'(MAX_HASHES);
        end else begin
            k_eff = KW'(r_hash_count);
        end
    end

    always_comb begin
        logic [HASH_W-1:0] base;
        logic              hit;
        n_state   = r_state;
        n_base    = r_base;
        n_step    = r_step;
        n_add     = r_add;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_m       = r_m;
        n_word    = r_word;
        n_bit     = r_bit;
        n_clr     = r_clr;
        n_valid   = 1'b0;
        n_present = r_present;
        ram_we    = 1'b0;
        ram_waddr = r_word;
        ram_wdata = ram_rdata | (64'd1 << r_bit);
        ram_raddr = div_rem[AW+5:6];
        div_req   = '0;
        base      = r_index_order ? i_hash_second : i_hash_first;
        hit       = ram_rdata[r_bit];
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_add  = i_req_type;
                    n_base = base;
                    n_step = r_index_order ? i_hash_first : i_hash_second;
                    n_k    = k_eff;
                    n_m    = m_eff[MW-1:0];
                    n_cnt  = '0;
                    if (k_eff == '0) begin
                        n_valid   = 1'b1;
                        n_present = !i_req_type;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = base[HASH_W-1] ? -base : base;
                        n_state          = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_word  = div_rem[AW+5:6];
                    n_bit   = div_rem[5:0];
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                ram_we = r_add;
                if ((!r_add && !hit) || (r_cnt + 1'b1 == r_k)) begin
                    n_valid   = 1'b1;
                    n_present = !r_add && hit;
                    n_state   = S_IDLE;
                end else begin
                    n_base           = r_base + r_step;
                    n_cnt            = r_cnt + 1'b1;
                    div_req.start    = 1'b1;
                    div_req.dividend = n_base[HASH_W-1] ? -n_base : n_base;
                    n_state          = S_DIV;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
        r_base    <= n_base;
        r_step    <= n_step;
        r_add     <= n_add;
        r_cnt     <= n_cnt;
        r_k       <= n_k;
        r_m       <= n_m;
        r_word    <= n_word;
        r_bit     <= n_bit;
        r_present <= n_present;
    end

    bfdh_ram #(
        .W(64),
        .D(WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bfdh_divider #(
        .MW(MW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (r_m),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_present = r_present;

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_valid)
        else $error("result during clearing pass");

    a_add_not_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_add) |-> !o_present)
        else $error("add reported present");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("remainder finished outside probe wait");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_done) |-> (div_rem < r_m))
        else $error("probe index beyond bit count");
endmodule
